// File: src/dle_pkg.sv
// ----------------------------------------------------------------------------
// dle_pkg
// Types, message codes and register indexes for the lease engine.
// ----------------------------------------------------------------------------
package dle_pkg;

   localparam logic [7:0] OP_BOOTREQUEST = 8'd1;
   localparam logic [7:0] MSG_DISCOVER   = 8'd1;
   localparam logic [7:0] MSG_REQUEST    = 8'd3;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_OFFER = 2'd1;
   localparam logic [1:0] KIND_ACK   = 2'd2;
   localparam logic [1:0] KIND_NAK   = 2'd3;

   localparam logic [2:0] REG_POOL_START    = 3'd0;
   localparam logic [2:0] REG_POOL_SIZE     = 3'd1;
   localparam logic [2:0] REG_SUBNET_MASK   = 3'd2;
   localparam logic [2:0] REG_GATEWAY_IP    = 3'd3;
   localparam logic [2:0] REG_SERVER_IP     = 3'd4;
   localparam logic [2:0] REG_LEASE_SECONDS = 3'd5;

   // Classified command handed from front to back.
   localparam logic [1:0] CMD_DROP     = 2'd0;
   localparam logic [1:0] CMD_DISCOVER = 2'd1;
   localparam logic [1:0] CMD_REQUEST  = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [47:0] mac;
      logic [31:0] xid;
      logic [31:0] req_ip;
      logic [31:0] ciaddr;
      logic [31:0] giaddr;
      logic        bcast;
      logic        sid_match;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] mac;
      logic [31:0] xid;
      logic [31:0] yiaddr;
      logic [31:0] ciaddr;
      logic [31:0] giaddr;
      logic        bcast;
      logic [31:0] dest;
      logic [31:0] renew;
      logic [31:0] rebind;
      logic [31:0] lease;
   } rsp_type;

   function automatic logic [31:0] directed_bcast(input logic [31:0] ip);
      logic [31:0] mask;
      if (!ip[31])
         mask = 32'hFF00_0000;
      else if (ip[31:30] == 2'b10)
         mask = 32'hFFFF_0000;
      else if (ip[31:29] == 3'b110)
         mask = 32'hFFFF_FF00;
      else
         mask = 32'h0;
      return ip | ~mask;
   endfunction

endpackage

// File: src/dle_front.sv
// ----------------------------------------------------------------------------
// dle_front
// Accepts classified message headers and queues them for the back end.
// ----------------------------------------------------------------------------
module dle_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  dle_pkg::cmd_type   in_cmd,
   output logic               q_valid,
   input  logic               q_ready,
   output dle_pkg::cmd_type   q_cmd
);
   import dle_pkg::*;

   localparam int DEPTH = 2;

   cmd_type    mem_ff [DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'(DEPTH));
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_cmd    = mem_ff[rp_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push)
         mem_ff[wp_ff] <= in_cmd;
   end
endmodule

// File: src/dle_back.sv
// ----------------------------------------------------------------------------
// dle_back
// Sequencer that searches the lease table slot by slot and builds replies.
// ----------------------------------------------------------------------------
module dle_back #(
   parameter int LEASE_SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  dle_pkg::cmd_type   q_cmd,
   input  logic [31:0]        pool_start,
   input  logic [4:0]         pool_size,
   input  logic [31:0]        gateway_ip,
   input  logic [31:0]        lease_seconds,
   output logic               out_valid,
   input  logic               out_ready,
   output dle_pkg::rsp_type   out_rsp
);
   import dle_pkg::*;

   localparam int SW = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
   localparam logic [SW:0] LAST = (SW + 1)'(LEASE_SLOTS - 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MAC   = 4'd1;  // find_mac scan
   localparam logic [3:0] ST_IP    = 4'd2;  // find_ip / free_slot scan
   localparam logic [3:0] ST_TRY   = 4'd3;  // decide one candidate address
   localparam logic [3:0] ST_DONE  = 4'd4;  // build reply
   localparam logic [3:0] ST_OUT   = 4'd5;

   logic [SW-1:0] idx;

   logic          vld_ff [LEASE_SLOTS];
   logic          lsd_ff [LEASE_SLOTS];
   logic [31:0]   ip_mem [LEASE_SLOTS];
   logic [47:0]   mac_mem [LEASE_SLOTS];

   logic [3:0]    st_ff;
   cmd_type       c_ff;
   logic [SW:0]   i_ff;
   logic          hit_ff;
   logic [SW-1:0] hs_ff;
   logic [31:0]   hip_ff;
   logic          fr_ff;
   logic [SW-1:0] fs_ff;
   logic [31:0]   key_ff;
   logic          req_try_ff;
   logic [5:0]    pi_ff;
   logic [1:0]    kind_ff;
   logic [SW-1:0] s_ff;
   logic          newmac_ff;
   rsp_type       r_ff;
   rsp_type       r_in;
   logic          ov_ff;

   logic [31:0]   cand;
   logic [31:0]   rip;
   assign idx      = i_ff[SW-1:0];
   assign q_ready  = (st_ff == ST_IDLE);
   assign out_valid = ov_ff;
   assign out_rsp  = r_ff;
   assign rip      = ip_mem[s_ff];

   always_comb begin
      r_in      = '0;
      r_in.kind = kind_ff;
      if (kind_ff == KIND_NAK) begin
         r_in.mac    = c_ff.mac;
         r_in.xid    = c_ff.xid;
         r_in.giaddr = c_ff.giaddr;
         r_in.bcast  = c_ff.bcast;
         r_in.dest   = 32'hFFFF_FFFF;
      end else if (kind_ff != KIND_NONE) begin
         r_in.mac    = (kind_ff == KIND_OFFER && newmac_ff) ? c_ff.mac : mac_mem[s_ff];
         r_in.xid    = c_ff.xid;
         r_in.yiaddr = rip;
         r_in.renew  = lease_seconds >> 1;
         r_in.rebind = 32'((35'(lease_seconds) * 35'd7) >> 3);
         r_in.lease  = lease_seconds;
         if (kind_ff == KIND_OFFER) begin
            r_in.giaddr = gateway_ip;
            r_in.dest   = directed_bcast(rip);
         end else begin
            r_in.ciaddr = rip;
            r_in.dest   = (c_ff.giaddr == 32'd0 && c_ff.ciaddr != 32'd0) ?
                          c_ff.ciaddr : directed_bcast(rip);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
         for (int k = 0; k < LEASE_SLOTS; k++) begin
            vld_ff[k] <= 1'b0;
            lsd_ff[k] <= 1'b0;
         end
      end else begin
         unique case (st_ff)
            ST_IDLE: if (q_valid) begin
               c_ff   <= q_cmd;
               i_ff   <= '0;
               hit_ff <= 1'b0;
               fr_ff  <= 1'b0;
               pi_ff  <= '0;
               newmac_ff <= 1'b0;
               kind_ff <= KIND_NONE;
               unique case (q_cmd.cmd)
                  CMD_DISCOVER: st_ff <= ST_MAC;
                  CMD_REQUEST: begin
                     if (q_cmd.sid_match) st_ff <= ST_MAC;
                     else begin
                        key_ff <= (q_cmd.ciaddr == 32'd0) ? q_cmd.req_ip : q_cmd.ciaddr;
                        st_ff  <= ST_IP;
                     end
                  end
                  default: st_ff <= ST_DONE;
               endcase
            end
            ST_MAC: begin
               if (vld_ff[idx] && mac_mem[idx] == c_ff.mac &&
                   (!hit_ff || ip_mem[idx] < hip_ff)) begin
                  hit_ff <= 1'b1;
                  hs_ff  <= idx;
                  hip_ff <= ip_mem[idx];
               end
               i_ff <= i_ff + 1'b1;
               if (i_ff == LAST) begin
                  st_ff <= ST_TRY;
                  req_try_ff <= (c_ff.req_ip != 32'd0);
               end
            end
            ST_IP: begin
               if (!hit_ff && vld_ff[idx] && ip_mem[idx] == key_ff) begin
                  hit_ff <= 1'b1;
                  hs_ff  <= idx;
               end
               if (!fr_ff && !vld_ff[idx]) begin
                  fr_ff <= 1'b1;
                  fs_ff <= idx;
               end
               i_ff <= i_ff + 1'b1;
               if (i_ff == LAST) st_ff <= ST_TRY;
            end
            ST_TRY: begin
               if (c_ff.cmd == CMD_REQUEST) begin
                  st_ff <= ST_DONE;
                  if (c_ff.sid_match) begin
                     if (hit_ff && hip_ff == c_ff.req_ip) begin
                        kind_ff <= KIND_ACK; s_ff <= hs_ff;
                     end else kind_ff <= KIND_NAK;
                  end else if (hit_ff) begin
                     kind_ff <= KIND_ACK; s_ff <= hs_ff;
                  end else if (c_ff.ciaddr != 32'd0) kind_ff <= KIND_NAK;
               end else if (hit_ff && !newmac_ff) begin
                  // Existing lease found by MAC.
                  kind_ff <= KIND_OFFER; s_ff <= hs_ff;
                  st_ff <= ST_DONE;
               end else if (!newmac_ff) begin
                  // Start allocation: first candidate.
                  newmac_ff <= 1'b1;
                  hit_ff <= 1'b0; fr_ff <= 1'b0; i_ff <= '0;
                  if (req_try_ff) begin
                     key_ff <= c_ff.req_ip; st_ff <= ST_IP;
                  end else if (pi_ff < 6'(pool_size)) begin
                     key_ff <= pool_start; st_ff <= ST_IP;
                  end else st_ff <= ST_DONE;
               end else begin
                  // A candidate address has been scanned.
                  if (hit_ff && !lsd_ff[hs_ff]) begin
                     kind_ff <= KIND_OFFER; s_ff <= hs_ff;
                     st_ff <= ST_DONE;
                  end else if (!hit_ff && fr_ff) begin
                     kind_ff <= KIND_OFFER; s_ff <= fs_ff;
                     vld_ff[fs_ff] <= 1'b1;
                     lsd_ff[fs_ff] <= 1'b0;
                     ip_mem[fs_ff] <= key_ff;
                     st_ff <= ST_DONE;
                  end else begin
                     hit_ff <= 1'b0; fr_ff <= 1'b0; i_ff <= '0;
                     if (req_try_ff) req_try_ff <= 1'b0;
                     else pi_ff <= pi_ff + 6'd1;
                     if ((req_try_ff ? 6'd0 : pi_ff + 6'd1) < 6'(pool_size)) begin
                        key_ff <= cand; st_ff <= ST_IP;
                     end else st_ff <= ST_DONE;
                  end
               end
            end
            ST_DONE: begin
               r_ff <= r_in;
               if (kind_ff == KIND_OFFER && newmac_ff) begin
                  mac_mem[s_ff] <= c_ff.mac;
                  lsd_ff[s_ff]  <= 1'b1;
               end else if (kind_ff == KIND_ACK) begin
                  lsd_ff[s_ff] <= 1'b1;
               end
               ov_ff <= 1'b1;
               st_ff <= ST_OUT;
            end
            ST_OUT: if (out_ready) begin
               ov_ff <= 1'b0;
               st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   // Next pool address after a rejected candidate.
   assign cand = pool_start + (req_try_ff ? 32'd0 : 32'(pi_ff) + 32'd1);

endmodule

// File: src/dhcp_lease_engine_top.sv
// ----------------------------------------------------------------------------
// dhcp_lease_engine_top
// DHCP server address allocation over a small lease table.
// ----------------------------------------------------------------------------
// Each request transaction carries one DHCP header and yields exactly one
// response transaction (reply_kind 0 when nothing is to be sent). A front
// queue of two entries takes headers while the back end works. The back end
// scans the lease table one slot per clock, and a DISCOVER that allocates
// rescans it for the requested address and for each pool address tried, up
// to pool_size of them. Registers are to be written through the csr_ port
// only while idle; the block itself does not enforce this.
module dhcp_lease_engine_top #(
   parameter int LEASE_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_on_served_port,
   input  logic [7:0]  req_opcode,
   input  logic [7:0]  req_msg_type,
   input  logic [47:0] req_client_mac,
   input  logic [31:0] req_trans_id,
   input  logic [31:0] req_requested_ip,
   input  logic [31:0] req_server_id,
   input  logic [31:0] req_client_ip,
   input  logic [31:0] req_relay_ip,
   input  logic        req_bcast_flag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_reply_kind,
   output logic [47:0] rsp_reply_mac,
   output logic [31:0] rsp_reply_xid,
   output logic [31:0] rsp_your_ip,
   output logic [31:0] rsp_reply_ciaddr,
   output logic [31:0] rsp_reply_giaddr,
   output logic        rsp_reply_bcast,
   output logic [31:0] rsp_dest_ip,
   output logic [31:0] rsp_renew_time,
   output logic [31:0] rsp_rebind_time,
   output logic [31:0] rsp_lease_time
);
   import dle_pkg::*;

   logic [31:0] pool_start_ff, gateway_ip_ff, server_ip_ff, lease_ff;
   logic [4:0]  pool_size_ff;
   cmd_type     in_cmd, q_cmd;
   rsp_type     rsp;
   logic        q_valid, q_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_start_ff  <= '0;
         pool_size_ff   <= '0;
         gateway_ip_ff  <= '0;
         server_ip_ff   <= '0;
         lease_ff       <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_POOL_START:    pool_start_ff  <= csr_data;
            REG_POOL_SIZE:     pool_size_ff   <= csr_data[4:0];
            // The subnet mask does not appear in any reply field.
            REG_SUBNET_MASK:   ;
            REG_GATEWAY_IP:    gateway_ip_ff  <= csr_data;
            REG_SERVER_IP:     server_ip_ff   <= csr_data;
            REG_LEASE_SECONDS: lease_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_cmd.cmd = CMD_DROP;
      if (req_on_served_port && req_opcode == OP_BOOTREQUEST) begin
         if (req_msg_type == MSG_DISCOVER) in_cmd.cmd = CMD_DISCOVER;
         else if (req_msg_type == MSG_REQUEST) in_cmd.cmd = CMD_REQUEST;
      end
      in_cmd.mac       = req_client_mac;
      in_cmd.xid       = req_trans_id;
      in_cmd.req_ip    = req_requested_ip;
      in_cmd.ciaddr    = req_client_ip;
      in_cmd.giaddr    = req_relay_ip;
      in_cmd.bcast     = req_bcast_flag;
      in_cmd.sid_match = (req_server_id == server_ip_ff);
   end

   dle_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_cmd,
      .q_valid, .q_ready, .q_cmd
   );

   dle_back #(.LEASE_SLOTS(LEASE_SLOTS)) u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_cmd,
      .pool_start(pool_start_ff), .pool_size(pool_size_ff),
      .gateway_ip(gateway_ip_ff), .lease_seconds(lease_ff),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_rsp(rsp)
   );

   assign rsp_reply_kind   = rsp.kind;
   assign rsp_reply_mac    = rsp.mac;
   assign rsp_reply_xid    = rsp.xid;
   assign rsp_your_ip      = rsp.yiaddr;
   assign rsp_reply_ciaddr = rsp.ciaddr;
   assign rsp_reply_giaddr = rsp.giaddr;
   assign rsp_reply_bcast  = rsp.bcast;
   assign rsp_dest_ip      = rsp.dest;
   assign rsp_renew_time   = rsp.renew;
   assign rsp_rebind_time  = rsp.rebind;
   assign rsp_lease_time   = rsp.lease;
endmodule

// File: dv/tb_dhcp_lease_engine_top.sv
// ----------------------------------------------------------------------------
// tb_dhcp_lease_engine_top
// Self-checking bench for the DHCP lease engine.
// ----------------------------------------------------------------------------
// Every header transaction yields one response transaction. A lease table
// predictor in the bench computes each expected response when the header is
// accepted. Responses are checked field by field in order while both sides
// idle at random over several phases and register settings.
// ----------------------------------------------------------------------------
module tb_dhcp_lease_engine_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dle_pkg::*;

   localparam int SLOTS = 16;
   localparam int WATCHDOG_LIMIT = 200000;

   typedef struct packed {
      logic        port;
      logic [7:0]  opcode;
      logic [7:0]  msg_type;
      logic [47:0] mac;
      logic [31:0] xid;
      logic [31:0] req_ip;
      logic [31:0] sid;
      logic [31:0] ciaddr;
      logic [31:0] giaddr;
      logic        bcast;
   } header_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   header_type hdr = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type got;

   dhcp_lease_engine_top #(.LEASE_SLOTS(SLOTS)) u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_on_served_port(hdr.port), .req_opcode(hdr.opcode),
      .req_msg_type(hdr.msg_type), .req_client_mac(hdr.mac),
      .req_trans_id(hdr.xid), .req_requested_ip(hdr.req_ip),
      .req_server_id(hdr.sid), .req_client_ip(hdr.ciaddr),
      .req_relay_ip(hdr.giaddr), .req_bcast_flag(hdr.bcast),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_reply_kind(got.kind), .rsp_reply_mac(got.mac),
      .rsp_reply_xid(got.xid), .rsp_your_ip(got.yiaddr),
      .rsp_reply_ciaddr(got.ciaddr), .rsp_reply_giaddr(got.giaddr),
      .rsp_reply_bcast(got.bcast), .rsp_dest_ip(got.dest),
      .rsp_renew_time(got.renew), .rsp_rebind_time(got.rebind),
      .rsp_lease_time(got.lease)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state: registers and lease table.
   logic [31:0] cfg_pool_start, cfg_gateway, cfg_server, cfg_lease;
   logic [4:0]  cfg_pool_size;
   logic        tbl_valid [SLOTS];
   logic        tbl_leased [SLOTS];
   logic [31:0] tbl_ip [SLOTS];
   logic [47:0] tbl_mac [SLOTS];
   logic [31:0] tbl_xid [SLOTS];

   header_type pending_headers[$];
   rsp_type expected_replies[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int quiet_cycles = 0;

   // Acceptance seen at the last rising edge, used by the driver.
   logic req_ready_seen = 1'b0;

   function automatic int lookup_ip(input logic [31:0] ip);
      for (int i = 0; i < SLOTS; i++)
         if (tbl_valid[i] && tbl_ip[i] == ip) return i;
      return -1;
   endfunction

   function automatic int lookup_mac(input logic [47:0] mac);
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++)
         if (tbl_valid[i] && tbl_mac[i] == mac)
            if (best < 0 || tbl_ip[i] < tbl_ip[best]) best = i;
      return best;
   endfunction

   function automatic int claim_addr(input logic [31:0] ip);
      int s;
      s = lookup_ip(ip);
      if (s >= 0) return tbl_leased[s] ? -1 : s;
      for (int i = 0; i < SLOTS; i++)
         if (!tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_leased[i] = 1'b0;
            tbl_ip[i] = ip;
            tbl_mac[i] = '0;
            tbl_xid[i] = '0;
            return i;
         end
      return -1;
   endfunction

   function automatic logic [31:0] classful_bcast(input logic [31:0] ip);
      logic [31:0] m;
      if (!ip[31]) m = 32'hFF00_0000;
      else if (ip[31:30] == 2'b10) m = 32'hFFFF_0000;
      else if (ip[31:29] == 3'b110) m = 32'hFFFF_FF00;
      else m = 32'h0;
      return ip | ~m;
   endfunction

   function automatic void fill_times(inout rsp_type r);
      logic [34:0] seven;
      seven = {3'b0, cfg_lease} * 35'd7;
      r.renew = cfg_lease >> 1;
      r.rebind = seven[34:3];
      r.lease = cfg_lease;
   endfunction

   function automatic rsp_type nak_reply(input header_type h);
      rsp_type r;
      r = '0;
      r.kind = KIND_NAK;
      r.mac = h.mac;
      r.xid = h.xid;
      r.giaddr = h.giaddr;
      r.bcast = h.bcast;
      r.dest = 32'hFFFF_FFFF;
      return r;
   endfunction

   function automatic rsp_type predict_reply(input header_type h);
      rsp_type r;
      int s;
      r = '0;
      if (!h.port || h.opcode != OP_BOOTREQUEST) return r;
      if (h.msg_type == MSG_DISCOVER) begin
         s = lookup_mac(h.mac);
         if (s < 0) begin
            if (h.req_ip != 0) s = claim_addr(h.req_ip);
            for (int i = 0; i < cfg_pool_size && s < 0; i++)
               s = claim_addr(cfg_pool_start + 32'(i));
            if (s < 0) return r;
            tbl_mac[s] = h.mac;
            tbl_leased[s] = 1'b1;
         end
         tbl_xid[s] = h.xid;
         r.kind = KIND_OFFER;
         r.mac = tbl_mac[s];
         r.xid = tbl_xid[s];
         r.yiaddr = tbl_ip[s];
         r.giaddr = cfg_gateway;
         r.dest = classful_bcast(tbl_ip[s]);
         fill_times(r);
         return r;
      end
      if (h.msg_type != MSG_REQUEST) return r;
      if (h.sid == cfg_server) begin
         s = lookup_mac(h.mac);
         if (s < 0 || tbl_ip[s] != h.req_ip) return nak_reply(h);
      end else if (h.ciaddr == 0) begin
         s = lookup_ip(h.req_ip);
         if (s < 0) return r;
      end else begin
         s = lookup_ip(h.ciaddr);
         if (s < 0) return nak_reply(h);
      end
      tbl_xid[s] = h.xid;
      tbl_leased[s] = 1'b1;
      r.kind = KIND_ACK;
      r.mac = tbl_mac[s];
      r.xid = tbl_xid[s];
      r.yiaddr = tbl_ip[s];
      r.ciaddr = tbl_ip[s];
      r.dest = (h.giaddr == 0 && h.ciaddr != 0) ? h.ciaddr : classful_bcast(tbl_ip[s]);
      fill_times(r);
      return r;
   endfunction

   // Driver: offers queued headers, idling at random between transactions.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready_seen) begin
            if (pending_headers.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               hdr <= pending_headers.pop_front();
               req_valid <= 1'b1;
            end else
               req_valid <= 1'b0;
         end else if (!req_valid && pending_headers.size() > 0
                      && $urandom_range(99) >= send_idle_pct) begin
            hdr <= pending_headers.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // Receiver: stalls at random, or holds off for a counted stretch.
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
         end else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: predicts on header acceptance and checks each response.
   always @(posedge clock) begin
      rsp_type exp_r;
      req_ready_seen <= !reset && req_valid && req_ready;
      if (!reset) begin
         quiet_cycles <= ((req_valid && req_ready) || (rsp_valid && rsp_ready)) ?
                         0 : quiet_cycles + 1;
         if (req_valid && req_ready)
            expected_replies.push_back(predict_reply(hdr));
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected response kind %0d", $time, got.kind);
               errors++;
            end else begin
               exp_r = expected_replies.pop_front();
               if (exp_r.kind != got.kind) begin
                  $display("%0t: reply_kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
                  errors++;
               end
               if (exp_r.mac != got.mac) begin
                  $display("%0t: reply_mac expected %h actual %h", $time, exp_r.mac, got.mac);
                  errors++;
               end
               if (exp_r.xid != got.xid) begin
                  $display("%0t: reply_xid expected %h actual %h", $time, exp_r.xid, got.xid);
                  errors++;
               end
               if (exp_r.yiaddr != got.yiaddr) begin
                  $display("%0t: your_ip expected %h actual %h", $time, exp_r.yiaddr,
                           got.yiaddr);
                  errors++;
               end
               if (exp_r.ciaddr != got.ciaddr) begin
                  $display("%0t: reply_ciaddr expected %h actual %h", $time, exp_r.ciaddr,
                           got.ciaddr);
                  errors++;
               end
               if (exp_r.giaddr != got.giaddr) begin
                  $display("%0t: reply_giaddr expected %h actual %h", $time, exp_r.giaddr,
                           got.giaddr);
                  errors++;
               end
               if (exp_r.bcast != got.bcast) begin
                  $display("%0t: reply_bcast expected %0d actual %0d", $time, exp_r.bcast,
                           got.bcast);
                  errors++;
               end
               if (exp_r.dest != got.dest) begin
                  $display("%0t: dest_ip expected %h actual %h", $time, exp_r.dest, got.dest);
                  errors++;
               end
               if (exp_r.renew != got.renew) begin
                  $display("%0t: renew_time expected %h actual %h", $time, exp_r.renew,
                           got.renew);
                  errors++;
               end
               if (exp_r.rebind != got.rebind) begin
                  $display("%0t: rebind_time expected %h actual %h", $time, exp_r.rebind,
                           got.rebind);
                  errors++;
               end
               if (exp_r.lease != got.lease) begin
                  $display("%0t: lease_time expected %h actual %h", $time, exp_r.lease,
                           got.lease);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on cycles with no transaction at all.
   always @(posedge clock) begin
      if (!reset && quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_POOL_START:    cfg_pool_start = val;
         REG_POOL_SIZE:     cfg_pool_size = val[4:0];
         REG_GATEWAY_IP:    cfg_gateway = val;
         REG_SERVER_IP:     cfg_server = val;
         REG_LEASE_SECONDS: cfg_lease = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_config(input logic [31:0] start, input logic [4:0] size,
                              input logic [31:0] gw, input logic [31:0] srv,
                              input logic [31:0] secs);
      write_reg(REG_POOL_START, start);
      write_reg(REG_POOL_SIZE, {27'b0, size});
      write_reg(REG_SUBNET_MASK, $urandom());
      write_reg(REG_GATEWAY_IP, gw);
      write_reg(REG_SERVER_IP, srv);
      write_reg(REG_LEASE_SECONDS, secs);
   endtask

   // Waits until every queued header is sent and every reply has come back,
   // and then waits on so the block is surely idle.
   task automatic drain();
      while (pending_headers.size() > 0 || req_valid || expected_replies.size() > 0)
         @(posedge clock);
      repeat (SLOTS * 40) @(posedge clock);
   endtask

   // Small MAC and address sets make hits in the lease table common.
   function automatic header_type random_header(input logic [31:0] start,
                                                input logic [31:0] srv);
      header_type h;
      int pick;
      h.port = ($urandom_range(19) != 0);
      h.opcode = ($urandom_range(19) != 0) ? OP_BOOTREQUEST : 8'($urandom());
      pick = $urandom_range(9);
      h.msg_type = (pick < 4) ? MSG_DISCOVER : (pick < 9) ? MSG_REQUEST : 8'($urandom());
      h.mac = ($urandom_range(9) != 0) ? 48'($urandom_range(11)) :
              {16'($urandom()), 32'($urandom())};
      h.xid = $urandom();
      pick = $urandom_range(3);
      h.req_ip = (pick == 0) ? 32'h0 : (pick == 3) ? $urandom() : start + $urandom_range(19);
      h.sid = ($urandom_range(1) != 0) ? srv : $urandom();
      pick = $urandom_range(2);
      h.ciaddr = (pick == 0) ? 32'h0 : (pick == 1) ? start + $urandom_range(19) : $urandom();
      h.giaddr = ($urandom_range(1) != 0) ? 32'h0 : $urandom();
      h.bcast = 1'($urandom_range(1));
      return h;
   endfunction

   function automatic header_type make_header(input logic [7:0] mtype, input logic [47:0] mac,
                                              input logic [31:0] req, input logic [31:0] sid,
                                              input logic [31:0] ci, input logic [31:0] gi);
      header_type h;
      h.port = 1'b1;
      h.opcode = OP_BOOTREQUEST;
      h.msg_type = mtype;
      h.mac = mac;
      h.xid = $urandom();
      h.req_ip = req;
      h.sid = sid;
      h.ciaddr = ci;
      h.giaddr = gi;
      h.bcast = 1'($urandom_range(1));
      return h;
   endfunction

   initial begin
      header_type h;
      logic [31:0] start, srv;
      cfg_pool_start = '0; cfg_pool_size = '0;
      cfg_gateway = '0; cfg_server = '0; cfg_lease = '0;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_leased[i] = 1'b0;
         tbl_ip[i] = '0;
         tbl_mac[i] = '0;
         tbl_xid[i] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty pool, drops, then allocation, class boundaries and the
      // request paths.
      pending_headers.push_back(make_header(MSG_DISCOVER, 48'h1, 32'h0, 32'h0, 32'h0, 32'h0));
      h = make_header(MSG_DISCOVER, 48'h1, 32'h0, 32'h0, 32'h0, 32'h0);
      h.port = 1'b0;
      pending_headers.push_back(h);
      h = make_header(MSG_REQUEST, 48'h1, 32'h0, 32'h0, 32'h0, 32'h0);
      h.opcode = 8'hFF;
      pending_headers.push_back(h);
      pending_headers.push_back(make_header(8'hFF, 48'h1, 32'h0, 32'h0, 32'h0, 32'h0));
      pending_headers.push_back(make_header(MSG_REQUEST, 48'h1, 32'h0, 32'h1, 32'h0,
                                            32'h0));
      drain();
      load_config(32'hC0A8_0A0E, 5'd4, 32'hC0A8_0A01, 32'hC0A8_0A02, 32'hFFFF_FFFF);
      pending_headers.push_back(make_header(MSG_DISCOVER, 48'hFFFF_FFFF_FFFF, 32'h0A00_0005,
                                            32'h0, 32'h0, 32'h0));
      pending_headers.push_back(make_header(MSG_DISCOVER, 48'hFFFF_FFFF_FFFF, 32'h0,
                                            32'h0, 32'h0, 32'h0));
      pending_headers.push_back(make_header(MSG_DISCOVER, 48'h2, 32'h0A00_0005, 32'h0,
                                            32'h0, 32'h0));
      pending_headers.push_back(make_header(MSG_DISCOVER, 48'h3, 32'h8000_0001, 32'h0,
                                            32'h0, 32'h0));
      pending_headers.push_back(make_header(MSG_DISCOVER, 48'h4, 32'hE000_0001, 32'h0,
                                            32'h0, 32'h0));
      pending_headers.push_back(make_header(MSG_DISCOVER, 48'h5, 32'hFFFF_FFFF, 32'h0,
                                            32'h0, 32'h0));
      pending_headers.push_back(make_header(MSG_REQUEST, 48'hFFFF_FFFF_FFFF, 32'h0A00_0005,
                                            32'hC0A8_0A02, 32'h0, 32'h0));
      pending_headers.push_back(make_header(MSG_REQUEST, 48'h2, 32'h0A00_0006,
                                            32'hC0A8_0A02, 32'h0, 32'hFFFF_FFFF));
      pending_headers.push_back(make_header(MSG_REQUEST, 48'h3, 32'h8000_0001, 32'h7,
                                            32'h0, 32'h0));
      pending_headers.push_back(make_header(MSG_REQUEST, 48'h3, 32'h1234_5678, 32'h7,
                                            32'h0, 32'h0));
      pending_headers.push_back(make_header(MSG_REQUEST, 48'h4, 32'h0, 32'h7,
                                            32'hE000_0001, 32'h0));
      pending_headers.push_back(make_header(MSG_REQUEST, 48'h4, 32'h0, 32'h7,
                                            32'hE000_0001, 32'h0A0A_0A0A));
      pending_headers.push_back(make_header(MSG_REQUEST, 48'h6, 32'h0, 32'h7,
                                            32'h0909_0909, 32'h0));
      drain();

      // Random phases, each with its own setting and idling pattern.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin start = 32'h0A00_0001; srv = 32'h0A00_00FE; end
            1: begin start = 32'hFFFF_FFF8; srv = 32'hFFFF_FFFF; end
            2: begin start = 32'h8010_0000; srv = 32'h0; end
            default: begin start = $urandom(); srv = $urandom(); end
         endcase
         load_config(start, (phase == 1) ? 5'd31 : (phase == 2) ? 5'd0 :
                     5'($urandom_range(16)), $urandom(), srv,
                     (phase == 2) ? 32'h0 : $urandom());
         send_idle_pct = (phase == 1 || phase == 3) ? 85 : (phase == 4) ? 36 : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? 85 : (phase == 4) ? 36 : 0;
         if (phase == 5) hold_off_cycles = 600;
         for (int n = 0; n < 90; n++) pending_headers.push_back(random_header(start, srv));
         drain();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;

      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
